// ----- rtl/six_channel_clock_divider_mixer_defines.svh -----
// Assertion macros shared by the clock divider mixer RTL.
// Included by the modules that carry concurrent assertions; needs nothing else.
`ifndef SIX_CHANNEL_CLOCK_DIVIDER_MIXER_DEFINES_SVH
`define SIX_CHANNEL_CLOCK_DIVIDER_MIXER_DEFINES_SVH

// General form: explicit clock and active-low reset.
`define SCDM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Short form for modules that use the house clock and reset names.
`define SCDM_ASSERT_STD(label, prop, msg) \
  `SCDM_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/scdm_pkg.sv -----
// Package of the six channel clock divider mixer: widths, constants, types and helpers.
// Used by the interfaces and by every module of the block; depends on nothing.
package scdm_pkg;

  localparam int NumChannels = 6;
  localparam int DivFields   = 6;
  localparam int DivW        = 5;
  localparam int StepW       = 20;
  localparam int DigitW      = 4;
  localparam int NumDigits   = StepW / DigitW;
  localparam int RemW        = 4;
  localparam int InMvW       = 15;
  localparam int OffsetW     = 11;
  localparam int MixW        = 14;
  localparam int GateW       = 6;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 30;

  typedef logic signed [InMvW-1:0]   in_mv_t;
  typedef logic signed [OffsetW-1:0] offset_t;
  typedef logic signed [MixW-1:0]    mix_t;
  typedef logic [GateW-1:0]          gate_t;
  typedef logic [CfgIdxW-1:0]        cfg_idx_t;
  typedef logic [CfgDataW-1:0]       cfg_data_t;
  typedef logic [StepW-1:0]          step_t;
  typedef logic [DivW-1:0]           div_t;
  typedef logic [RemW-1:0]           rem_t;

  localparam step_t     StepWrap     = 20'd720720;
  localparam step_t     StepOne      = 20'd1;
  localparam in_mv_t    ClockHighMv  = 15'sd3000;
  localparam in_mv_t    ResetLowMv   = 15'sd100;
  localparam in_mv_t    ResetHighMv  = 15'sd1000;
  localparam cfg_data_t DivisorReset = 30'd545427554;
  localparam div_t      DivMin       = 5'd2;
  localparam div_t      DivMax       = 5'd16;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgDivisorSet = 3'd0,
    CfgOffsetOne  = 3'd1,
    CfgOffsetTwo  = 3'd2,
    CfgOffsetThree = 3'd3,
    CfgOffsetFour = 3'd4,
    CfgOffsetFive = 3'd5,
    CfgOffsetSix  = 3'd6
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic rem_step;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_digit;
  } dp_status_t;

  // Divisor fields outside 2..16 are pulled to the nearest bound.
  function automatic div_t clamp_div(div_t field);
    div_t res;
    res = field;
    if (field < DivMin) begin
      res = DivMin;
    end else if (field > DivMax) begin
      res = DivMax;
    end
    return res;
  endfunction

endpackage

// ----- rtl/scdm_if.sv -----
// Handshake interfaces of the clock divider mixer: tick input, result output, config write.
// Depends on scdm_pkg for the payload types.
interface scdm_in_if;
  import scdm_pkg::*;
  logic   valid;
  logic   ready;
  in_mv_t clock_mv;
  in_mv_t reset_mv;
  modport source (output valid, output clock_mv, output reset_mv, input ready);
  modport sink (input valid, input clock_mv, input reset_mv, output ready);
endinterface

interface scdm_out_if;
  import scdm_pkg::*;
  logic  valid;
  logic  ready;
  mix_t  mix_mv;
  gate_t gate_bits;
  modport source (output valid, output mix_mv, output gate_bits, input ready);
  modport sink (input valid, input mix_mv, input gate_bits, output ready);
endinterface

interface scdm_cfg_if;
  import scdm_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/scdm_datapath.sv -----
// Datapath of the clock divider mixer: config registers, step counter, channel lanes, output.
// Depends on scdm_pkg and the assertion macros header.
`include "six_channel_clock_divider_mixer_defines.svh"

module scdm_datapath #(
  parameter int CHANNELS = scdm_pkg::NumChannels
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scdm_pkg::dp_cmd_t    cmd_i,
  output scdm_pkg::dp_status_t status_o,
  input  scdm_pkg::in_mv_t     clock_mv_i,
  input  scdm_pkg::in_mv_t     reset_mv_i,
  input  logic                 cfg_valid_i,
  input  scdm_pkg::cfg_idx_t   cfg_index_i,
  input  scdm_pkg::cfg_data_t  cfg_data_i,
  output scdm_pkg::mix_t       mix_mv_o,
  output scdm_pkg::gate_t      gate_bits_o
);
  import scdm_pkg::*;

  localparam int DigCntW = $clog2(NumDigits);

  cfg_data_t            divisor_set_q;
  offset_t              offset_q [DivFields];
  cfg_idx_t             off_idx;
  step_t                step_q, step_d, step_inc;
  logic                 clk_was_q, trig_q, trig_d;
  logic                 clk_high, reset_edge;
  step_t                shift_q;
  logic [DigCntW-1:0]   digit_q;
  div_t                 div_lane  [CHANNELS];
  rem_t                 rem_q     [CHANNELS];
  rem_t                 rem_d     [CHANNELS];
  offset_t              lane_off  [CHANNELS];
  logic [CHANNELS-1:0]  lane_gate;
  mix_t                 mix_sum, mix_q;
  gate_t                gate_next, gate_q;

  // Configuration writes; indexes beyond the list are dropped.
  assign off_idx = cfg_idx_t'(cfg_index_i - cfg_idx_t'(CfgOffsetOne));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_set_q <= DivisorReset;
      for (int i = 0; i < DivFields; i++) begin
        offset_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i) inside
        CfgDivisorSet: begin
          divisor_set_q <= cfg_data_i;
        end
        [CfgOffsetOne:CfgOffsetSix]: begin
          offset_q[off_idx] <= offset_t'(cfg_data_i[OffsetW-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // Schmitt trigger on the reset voltage; its rising edge clears the counter.
  always_comb begin
    trig_d     = trig_q;
    reset_edge = 1'b0;
    if (trig_q) begin
      if (reset_mv_i <= ResetLowMv) begin
        trig_d = 1'b0;
      end
    end else if (reset_mv_i >= ResetHighMv) begin
      trig_d     = 1'b1;
      reset_edge = 1'b1;
    end
  end

  // Clock edge detection and the wrapping step counter.
  assign clk_high = clock_mv_i > ClockHighMv;
  assign step_inc = step_q + StepOne;

  always_comb begin
    step_d = step_q;
    if (reset_edge) begin
      step_d = '0;
    end else if (clk_high && !clk_was_q) begin
      step_d = (step_inc > StepWrap) ? StepOne : step_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      clk_was_q <= 1'b0;
      trig_q    <= 1'b0;
    end else if (cmd_i.start) begin
      step_q    <= step_d;
      clk_was_q <= clk_high;
      trig_q    <= trig_d;
    end
  end

  // The new count is fed to the lanes one digit at a time, most significant first.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      shift_q <= step_d;
    end else if (cmd_i.rem_step) begin
      shift_q <= shift_q << DigitW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else if (cmd_i.start) begin
      digit_q <= '0;
    end else if (cmd_i.rem_step) begin
      digit_q <= status_o.last_digit ? '0 : digit_q + 1'b1;
    end
  end

  assign status_o.last_digit = digit_q == DigCntW'(NumDigits - 1);

  // One remainder lane per channel: four restoring steps per cycle.
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    rem_t          acc;
    logic [RemW:0] trial;

    if (g < DivFields) begin : g_field
      assign div_lane[g] = clamp_div(divisor_set_q[g*DivW +: DivW]);
      assign lane_off[g] = offset_q[g];
    end else begin : g_nofield
      assign div_lane[g] = DivMin;
      assign lane_off[g] = '0;
    end

    always_comb begin
      acc   = rem_q[g];
      trial = '0;
      for (int b = DigitW - 1; b >= 0; b--) begin
        trial = {acc, shift_q[StepW-DigitW+b]};
        if (trial >= (RemW+1)'(div_lane[g])) begin
          trial = trial - (RemW+1)'(div_lane[g]);
        end
        acc = trial[RemW-1:0];
      end
      rem_d[g] = acc;
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.start) begin
        rem_q[g] <= '0;
      end else if (cmd_i.rem_step) begin
        rem_q[g] <= rem_d[g];
      end
    end

    // High half of the period: twice the remainder below the divisor.
    assign lane_gate[g] = {rem_q[g], 1'b0} < (RemW+1)'(div_lane[g]);
  end

  // Gate bits exist only for the channels that have a field.
  for (genvar g = 0; g < GateW; g++) begin : g_gate
    if (g < CHANNELS) begin : g_used
      assign gate_next[g] = lane_gate[g];
    end else begin : g_unused
      assign gate_next[g] = 1'b0;
    end
  end

  // Sum of the offsets of the channels that are high.
  always_comb begin
    mix_sum = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (lane_gate[i]) begin
        mix_sum = mix_sum + mix_t'(lane_off[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mix_q  <= mix_sum;
      gate_q <= gate_next;
    end
  end

  assign mix_mv_o    = mix_q;
  assign gate_bits_o = gate_q;

  `SCDM_ASSERT_STD(a_step_below_wrap, step_q <= StepWrap, "step count beyond wrap point")

endmodule

// ----- rtl/scdm_ctrl.sv -----
// Controller of the clock divider mixer: item handshakes and sequencing of the datapath.
// Depends on scdm_pkg and the assertion macros header.
`include "six_channel_clock_divider_mixer_defines.svh"

module scdm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output scdm_pkg::dp_cmd_t    cmd_o,
  input  scdm_pkg::dp_status_t status_i
);
  import scdm_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StDigits = 2'd1;
  localparam logic [1:0] StDone   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state, datapath commands and output valid.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StDigits;
        end
      end
      StDigits: begin
        cmd_o.rem_step = 1'b1;
        if (status_i.last_digit) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;

  `SCDM_ASSERT_STD(a_accept_starts_digits, (in_valid_i && in_ready_o) |=> state_q == StDigits, "accepted item did not start the digit pass")
  `SCDM_ASSERT_STD(a_digits_then_done, (state_q == StDigits && status_i.last_digit) |=> state_q == StDone, "digit pass did not finish")
  `SCDM_ASSERT_STD(a_result_from_done, $rose(out_valid_q) |-> $past(state_q) == StDone, "result shown outside the done step")
  `SCDM_ASSERT_STD(a_stall_holds, (state_q == StDone && out_valid_q && !out_ready_i) |=> (state_q == StDone && out_valid_q), "pending result overwritten")

endmodule

// ----- rtl/six_channel_clock_divider_mixer.sv -----
// Six channel clock divider with offset mixer, top level.
// Depends on scdm_pkg, the interfaces in scdm_if.sv, scdm_ctrl and scdm_datapath.
//
// Each input item is one sample tick and yields exactly one result item. The
// accepting edge updates the reset trigger, the clock history and the step
// counter; then every channel lane reduces the 20-bit count modulo its divisor
// four bits at a time, most significant digit first; and a final step, once the
// output register is free or being emptied, loads the gate bits and the offset
// sum into the output register. The next item is taken as soon as the previous
// one has reached the output register; a result that the sink has not taken
// holds back only the loading of the next one.
// Configuration writes are always taken and should be made while the block is idle.

module six_channel_clock_divider_mixer #(
  parameter int CHANNELS = scdm_pkg::NumChannels
) (
  input logic       clk_i,
  input logic       rst_ni,
  scdm_in_if.sink   in_i,
  scdm_out_if.source out_o,
  scdm_cfg_if.sink  cfg_i
);
  import scdm_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Configuration registers accept a write in every cycle.
  assign cfg_i.ready = 1'b1;

  scdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (dp_cmd),
    .status_i    (dp_status)
  );

  scdm_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .clock_mv_i  (in_i.clock_mv),
    .reset_mv_i  (in_i.reset_mv),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .mix_mv_o    (out_o.mix_mv),
    .gate_bits_o (out_o.gate_bits)
  );

endmodule

// ----- tb/sv/tb_six_channel_clock_divider_mixer.sv -----
// Testbench of the six channel clock divider mixer: directed and random sample ticks
// checked against a cycle-free model of the step counter, gates and offset sum.
// Depends on scdm_pkg, the interfaces in scdm_if.sv and the block's top level.
module tb_six_channel_clock_divider_mixer;
  import scdm_pkg::*;

  localparam cfg_idx_t CfgUnmapped  = 3'd7;
  localparam int       SettleCycles = 12;
  localparam int       IdleLimit    = 4000;
  localparam int       PhaseItems   = 150;
  localparam int       NumPhases    = 6;
  localparam int       LongHoldOff  = 300;

  typedef enum int {SetClampLow, SetClampHigh, SetMixed, SetRandom} setting_e;

  // Tracks step counter, gates and offset sum, and holds the results still owed.
  class gate_mix_tracker;
    cfg_data_t divisors;
    offset_t   offsets [NumChannels];
    step_t     step;
    bit        clock_was_high;
    bit        trigger_high;
    mix_t      exp_mix_q [$];
    gate_t     exp_gate_q [$];
    int        mismatches;

    function new();
      divisors = DivisorReset;
      foreach (offsets[ch]) offsets[ch] = '0;
      step = '0;
      clock_was_high = 1'b0;
      trigger_high = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return exp_mix_q.size();
    endfunction

    // Writes to the unused index leave every register as it was.
    function void write_register(cfg_idx_t idx, cfg_data_t data);
      if (idx == CfgDivisorSet) begin
        divisors = data;
      end else if (idx >= CfgOffsetOne && idx <= CfgOffsetSix) begin
        offsets[idx - CfgOffsetOne] = data[OffsetW-1:0];
      end
    endfunction

    function void note_tick(in_mv_t clock_mv, in_mv_t reset_mv);
      bit   rst_rise;
      bit   clock_high;
      int   sum;
      int   div;
      gate_t gates;
      rst_rise = 1'b0;
      clock_high = int'(clock_mv) > int'(ClockHighMv);
      sum = 0;
      gates = '0;
      // Schmitt trigger on the reset voltage; only its rising edge clears the count.
      if (trigger_high) begin
        if (int'(reset_mv) <= int'(ResetLowMv)) trigger_high = 1'b0;
      end else if (int'(reset_mv) >= int'(ResetHighMv)) begin
        trigger_high = 1'b1;
        rst_rise = 1'b1;
      end
      // A reset edge wins over a clock edge on the same tick.
      if (rst_rise) begin
        step = '0;
      end else if (clock_high && !clock_was_high) begin
        step = step + StepOne;
        if (step > StepWrap) step = StepOne;
      end
      clock_was_high = clock_high;
      for (int ch = 0; ch < NumChannels; ch++) begin
        div = int'(divisors[DivW*ch +: DivW]);
        if (div < int'(DivMin)) div = int'(DivMin);
        if (div > int'(DivMax)) div = int'(DivMax);
        if ((int'(step) % div) * 2 < div) begin
          gates[ch] = 1'b1;
          sum += int'(offsets[ch]);
        end
      end
      exp_mix_q.push_back(mix_t'(sum));
      exp_gate_q.push_back(gates);
    endfunction

    function void flag(string field, int exp_v, int got_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0d, got %0d", field, exp_v, got_v);
    endfunction

    function void check_result(mix_t mix_mv, gate_t gate_bits);
      mix_t  exp_mix;
      gate_t exp_gates;
      if (exp_mix_q.size() == 0) begin
        flag("result with nothing owed, gate_bits", -1, int'(gate_bits));
        return;
      end
      exp_mix = exp_mix_q.pop_front();
      exp_gates = exp_gate_q.pop_front();
      if (mix_mv != exp_mix) flag("mix_mv", int'(exp_mix), int'(mix_mv));
      if (gate_bits != exp_gates) flag("gate_bits", int'(exp_gates), int'(gate_bits));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  scdm_in_if  in_if ();
  scdm_out_if out_if ();
  scdm_cfg_if cfg_if ();

  six_channel_clock_divider_mixer dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  gate_mix_tracker tracker;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_off_cycles;
  int  idle_cycles;
  bit  clock_level;

  // Clock, period of four time units.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result sink: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Handshake monitor and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) tracker.check_result(out_if.mix_mv, out_if.gate_bits);
      if (cfg_if.valid && cfg_if.ready) tracker.write_register(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) tracker.note_tick(in_if.clock_mv, in_if.reset_mv);
      if ((out_if.valid && out_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (in_if.valid && in_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offers one tick, after a random idle stretch, and waits for it to be taken.
  task automatic send_tick(int clock_mv, int reset_mv);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.clock_mv <= in_mv_t'(clock_mv);
    in_if.reset_mv <= in_mv_t'(reset_mv);
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Lets every owed result come out and the pipeline empty.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic int rand_mv(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Mostly clean clock pulses with the reset low, salted with threshold values,
  // reset pulses, readings between the reset thresholds and raw field values.
  task automatic random_tick(output int clock_mv, output int reset_mv);
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) begin
      clock_mv = int'(in_mv_t'($urandom));
    end else if (sel < 14) begin
      clock_mv = rand_mv(2999, 3002);
    end else begin
      if ($urandom_range(99) < 60) clock_level = !clock_level;
      clock_mv = clock_level ? rand_mv(3001, 12000) : rand_mv(-12000, 3000);
    end
    sel = $urandom_range(99);
    if (sel < 86) begin
      reset_mv = rand_mv(-12000, 100);
    end else if (sel < 91) begin
      reset_mv = rand_mv(101, 999);
    end else if (sel < 97) begin
      reset_mv = rand_mv(1000, 12000);
    end else begin
      reset_mv = int'(in_mv_t'($urandom));
    end
  endtask

  task automatic program_setting(setting_e kind);
    case (kind)
      SetClampLow: begin
        write_reg(CfgDivisorSet, '0);
        for (int ch = 0; ch < NumChannels; ch++)
          write_reg(cfg_idx_t'(CfgOffsetOne + ch), cfg_data_t'(1023));
      end
      SetClampHigh: begin
        write_reg(CfgDivisorSet, '1);
        for (int ch = 0; ch < NumChannels; ch++)
          write_reg(cfg_idx_t'(CfgOffsetOne + ch), cfg_data_t'(-1024));
      end
      SetMixed: begin
        // Fields 1 and 17 fall outside the divisor range; 2 and 16 sit on its bounds.
        write_reg(CfgDivisorSet, {5'd9, 5'd15, 5'd16, 5'd2, 5'd17, 5'd1});
        write_reg(CfgOffsetOne, cfg_data_t'(1000));
        write_reg(CfgOffsetTwo, cfg_data_t'(-1000));
        write_reg(CfgOffsetThree, cfg_data_t'(1));
        write_reg(CfgOffsetFour, cfg_data_t'(-1));
        write_reg(CfgOffsetFive, cfg_data_t'(500));
        write_reg(CfgOffsetSix, cfg_data_t'(-500));
        write_reg(CfgUnmapped, cfg_data_t'($urandom));
      end
      default: begin
        write_reg(CfgDivisorSet, cfg_data_t'($urandom));
        for (int ch = 0; ch < NumChannels; ch++) begin
          if ($urandom_range(1) == 0) begin
            write_reg(cfg_idx_t'(CfgOffsetOne + ch), cfg_data_t'(rand_mv(-1000, 1000)));
          end else begin
            write_reg(cfg_idx_t'(CfgOffsetOne + ch), cfg_data_t'($urandom));
          end
        end
      end
    endcase
  endtask

  initial begin
    int clock_mv;
    int reset_mv;
    tracker = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.clock_mv = '0;
    in_if.reset_mv = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    idle_cycles = 0;
    clock_level = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration, then the clock threshold at and just above 3000 mV.
    send_tick(0, 0);
    send_tick(5000, 0);
    send_tick(0, 0);
    send_tick(5000, 0);
    send_tick(3000, 0);
    send_tick(3001, 0);
    wait_idle();
    program_setting(SetMixed);

    // Field extremes and the reset trigger around and on its thresholds.
    send_tick(-16384, -16384);
    send_tick(16383, 0);
    send_tick(16383, 999);
    send_tick(0, 1000);
    send_tick(5000, 500);
    send_tick(0, 101);
    send_tick(5000, 1000);
    send_tick(0, 100);
    // Reset edge and clock edge together: the count clears.
    send_tick(5000, 1000);
    send_tick(0, 16383);
    send_tick(0, -12000);
    send_tick(12000, 12000);
    send_tick(-12000, 0);
    send_tick(3001, 0);
    send_tick(2999, 0);
    send_tick(3000, 0);
    wait_idle();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: program_setting(SetClampLow);
        1: program_setting(SetClampHigh);
        default: program_setting(SetRandom);
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        // The sink holds off long enough for the block to fill and stall its input.
        if (phase == 0 && n == 40) hold_off_cycles = LongHoldOff;
        // The source pauses until the block has given back every owed result.
        if (phase == 3 && n == 75) wait_idle();
        random_tick(clock_mv, reset_mv);
        send_tick(clock_mv, reset_mv);
      end
      wait_idle();
    end

    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/scdm_pkg.sv
rtl/scdm_if.sv
rtl/scdm_datapath.sv
rtl/scdm_ctrl.sv
rtl/six_channel_clock_divider_mixer.sv
tb/sv/tb_six_channel_clock_divider_mixer.sv
